@@ design/bblur_pkg.sv @@
// Shared types, constants and helper functions for the 3x3 box blur.
package bblur_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CFG_W     = 12;
   localparam int EW_W      = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int ROW_W     = 12;
   localparam int PIX_W     = 24;
   localparam int NUM_ROWS  = 3;
   localparam int DEPTH     = NUM_ROWS * MAX_WIDTH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int NUM_TAPS  = 9;
   localparam int CNT_W     = 4;
   localparam int SUM_W     = 12;
   localparam int NUM_W     = 13;
   localparam int REC_W     = 16;
   localparam int PROD_W    = NUM_W + REC_W;
   localparam int Q_W       = 9;
   localparam int DEN_W     = 5;
   localparam int BACK_W    = Q_W + DEN_W;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   typedef struct packed {
      logic       command;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic       frame_done;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic             vld;
      logic [PIX_W-1:0] pix;
   } tap_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FLUSH,
      ST_SUM,
      ST_AVG,
      ST_OUT
   } seq_state_type;

   // row number modulo 3: 4**k is 1 mod 3, so fold base-4 digits
   function automatic logic [1:0] mod3(input logic [ROW_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8]) + 5'(v[11:10]);
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      u = 3'(t[1:0]) + 3'(t[2]);
      if (u >= 3'd3) begin
         u = u - 3'd3;
      end
      return u[1:0];
   endfunction

   // floor(2**16 / (2*n)) for the neighbor counts that can occur
   function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] n);
      logic [REC_W-1:0] r;
      unique case (n)
         4'd1:    r = 16'd32768;
         4'd2:    r = 16'd16384;
         4'd3:    r = 16'd10922;
         4'd4:    r = 16'd8192;
         4'd6:    r = 16'd5461;
         4'd9:    r = 16'd3640;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

@@ design/box_blur_3x3_edge_clipped.sv @@
// Top level of the 3x3 edge-clipped box blur: sequencer, row store, tap chain and averager.
//
// Pixels arrive in raster order on the req_ channel (valid/stall), results
// leave on the rsp_ channel. A transaction is accepted on a rising edge
// with valid high and stall low. The csr_ port writes frame_width (index 0)
// and frame_height (index 1); write only while the block is idle.
// Output trails input by one row and one column; after the last pixel of a
// frame, drain transactions deliver the last row, one pixel each.
// Each result is built by reading its up-to-nine neighbors from the single
// read port of the row store, one per cycle, into a chain of nine tap cells,
// then a three-stage averager. A pixel that closes a row can produce two
// results, which are built one after the other.
// One transaction is in flight at a time;
// req_stall stays high until all its results are taken.
// A stalled result holds on rsp_data until taken. Synchronous reset clears
// the counters, restores the 640x480 defaults and empties the channel; the
// row store is not cleared.
module box_blur_3x3_edge_clipped import bblur_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   seq_state_type    state_ff, state_in;
   logic [CFG_W-1:0] fw_ff, fw_in, fh_ff, fh_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] drain_ff, drain_in;
   logic             fc_ff, fc_in;
   logic [ROW_W-1:0] em_row_ff, em_row_in;
   logic [COL_W-1:0] em_x_ff, em_x_in;
   logic             em_below_ff, em_below_in;
   logic             em_last_ff, em_last_in;
   logic             em_done_ff, em_done_in;
   logic             em2_ff, em2_in;
   logic [COL_W-1:0] em2_x_ff, em2_x_in;
   logic [1:0]       kr_ff, kr_in, kc_ff, kc_in;
   logic             rd_pend_ff, rd_mask_ff, rd_mask_in;
   rsp_type          rsp_ff, rsp_in;

   logic [EW_W-1:0]  w_eff;
   logic [COL_W-1:0] wm1;
   logic [ROW_W-1:0] hm1;
   logic [ROW_W-1:0] r_cur;
   logic [COL_W-1:0] c_cur;
   logic [COL_W-1:0] d_cur;
   logic             accept;
   logic             pix_emit;
   logic             ram_we;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic [1:0]       rm, slot;
   logic [COL_W-1:0] rd_col;
   logic             rd_vld;
   tap_type          ram_tap;
   tap_type          tap_q [NUM_TAPS];
   logic             avg_done;
   logic [7:0]       avg [3];

   // effective frame geometry and clamped counters
   always_comb begin
      if (fw_ff == '0) begin
         w_eff = EW_W'(1);
      end else if (EW_W'(fw_ff) > EW_W'(MAX_WIDTH)) begin
         w_eff = EW_W'(MAX_WIDTH);
      end else begin
         w_eff = EW_W'(fw_ff);
      end
      wm1   = COL_W'(w_eff - EW_W'(1));
      hm1   = (fh_ff == '0) ? '0 : ROW_W'(fh_ff - CFG_W'(1));
      r_cur = (row_ff >= hm1) ? hm1 : row_ff;
      c_cur = (col_ff >= wm1) ? wm1 : col_ff;
      d_cur = (drain_ff >= wm1) ? wm1 : drain_ff;
   end

   assign accept   = req_valid && !req_stall;
   assign pix_emit = (r_cur != '0) && ((c_cur != '0) || (c_cur == wm1));
   assign wr_addr  = ADDR_W'(mod3(r_cur)) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_cur);

   // window position for the current read step
   always_comb begin
      rm = mod3(em_row_ff);
      unique case (kr_ff)
         2'd0:    slot = (rm == 2'd0) ? 2'd2 : rm - 2'd1;
         2'd2:    slot = (rm == 2'd2) ? 2'd0 : rm + 2'd1;
         default: slot = rm;
      endcase
      unique case (kc_ff)
         2'd0:    rd_col = em_x_ff - COL_W'(1);
         2'd2:    rd_col = em_x_ff + COL_W'(1);
         default: rd_col = em_x_ff;
      endcase
      rd_vld = 1'b1;
      if (kr_ff == 2'd0 && em_row_ff == '0) begin
         rd_vld = 1'b0;
      end
      if (kr_ff == 2'd2 && !em_below_ff) begin
         rd_vld = 1'b0;
      end
      if (kc_ff == 2'd0 && em_x_ff == '0) begin
         rd_vld = 1'b0;
      end
      if (kc_ff == 2'd2 && em_x_ff == wm1) begin
         rd_vld = 1'b0;
      end
      rd_addr = ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_DRAIN) begin
                  if (fc_ff) begin
                     state_in = ST_READ;
                  end
               end else if (!fc_ff && pix_emit) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (kr_ff == 2'd2 && kc_ff == 2'd2) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_SUM;
         ST_SUM:   state_in = ST_AVG;
         ST_AVG: begin
            if (avg_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = em2_ff ? ST_READ : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and counters
   always_comb begin
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      drain_in    = drain_ff;
      fc_in       = fc_ff;
      em_row_in   = em_row_ff;
      em_x_in     = em_x_ff;
      em_below_in = em_below_ff;
      em_last_in  = em_last_ff;
      em_done_in  = em_done_ff;
      em2_in      = em2_ff;
      em2_x_in    = em2_x_ff;
      kr_in       = '0;
      kc_in       = '0;
      rd_mask_in  = 1'b0;
      rsp_in      = rsp_ff;
      ram_we      = 1'b0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fw_in = csr_data;
            CSR_FRAME_HEIGHT: fh_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_DRAIN) begin
                  if (fc_ff) begin
                     em_row_in   = hm1;
                     em_x_in     = d_cur;
                     em_below_in = 1'b0;
                     em_last_in  = 1'b1;
                     em_done_in  = (d_cur == wm1);
                     em2_in      = 1'b0;
                     if (d_cur == wm1) begin
                        row_in   = '0;
                        col_in   = '0;
                        drain_in = '0;
                        fc_in    = 1'b0;
                     end else begin
                        drain_in = d_cur + COL_W'(1);
                     end
                  end
               end else if (!fc_ff) begin
                  ram_we      = 1'b1;
                  em_row_in   = r_cur - ROW_W'(1);
                  em_x_in     = (c_cur != '0) ? c_cur - COL_W'(1) : c_cur;
                  em_below_in = 1'b1;
                  em_done_in  = 1'b0;
                  em2_in      = pix_emit && (c_cur != '0) && (c_cur == wm1);
                  em2_x_in    = c_cur;
                  em_last_in  = !((c_cur != '0) && (c_cur == wm1));
                  if (c_cur == wm1) begin
                     col_in = '0;
                     if (r_cur == hm1) begin
                        row_in   = r_cur;
                        drain_in = '0;
                        fc_in    = 1'b1;
                     end else begin
                        row_in = r_cur + ROW_W'(1);
                     end
                  end else begin
                     col_in = c_cur + COL_W'(1);
                     row_in = r_cur;
                  end
               end
            end
         end
         ST_READ: begin
            rd_mask_in = rd_vld;
            if (kc_ff == 2'd2) begin
               kc_in = '0;
               kr_in = kr_ff + 2'd1;
            end else begin
               kc_in = kc_ff + 2'd1;
               kr_in = kr_ff;
            end
         end
         ST_AVG: begin
            if (avg_done) begin
               rsp_in.out_red    = avg[2];
               rsp_in.out_green  = avg[1];
               rsp_in.out_blue   = avg[0];
               rsp_in.frame_done = em_done_ff;
               rsp_in.run_last   = em_last_ff;
            end
         end
         ST_OUT: begin
            if (!rsp_stall && em2_ff) begin
               em_x_in    = em2_x_ff;
               em_last_in = 1'b1;
               em2_in     = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fw_ff      <= WIDTH_RESET;
         fh_ff      <= HEIGHT_RESET;
         row_ff     <= '0;
         col_ff     <= '0;
         drain_ff   <= '0;
         fc_ff      <= 1'b0;
         em2_ff     <= 1'b0;
         kr_ff      <= '0;
         kc_ff      <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         drain_ff   <= drain_in;
         fc_ff      <= fc_in;
         em2_ff     <= em2_in;
         kr_ff      <= kr_in;
         kc_ff      <= kc_in;
         rd_pend_ff <= (state_ff == ST_READ);
      end
   end

   always_ff @(posedge clock) begin
      em_row_ff   <= em_row_in;
      em_x_ff     <= em_x_in;
      em_below_ff <= em_below_in;
      em_last_ff  <= em_last_in;
      em_done_ff  <= em_done_in;
      em2_x_ff    <= em2_x_in;
      rd_mask_ff  <= rd_mask_in;
      rsp_ff      <= rsp_in;
   end

   bblur_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data ({req_data.in_red, req_data.in_green, req_data.in_blue}),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ram_tap = '{vld: rd_mask_ff, pix: rd_data};

   for (genvar i = 0; i < NUM_TAPS; i++) begin : g_tap
      if (i == 0) begin : g_head
         bblur_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (rd_pend_ff),
            .tap_in  (ram_tap),
            .tap_out (tap_q[i])
         );
      end else begin : g_body
         bblur_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (rd_pend_ff),
            .tap_in  (tap_q[i-1]),
            .tap_out (tap_q[i])
         );
      end
   end

   bblur_avg u_avg (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_SUM),
      .taps  (tap_q),
      .done  (avg_done),
      .avg   (avg)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data  = rsp_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.run_last)
      else $error("frame_done without run_last");

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_complete_col_zero: assert property (@(posedge clock) disable iff (reset)
      fc_ff |-> col_ff == '0)
      else $error("column counter not cleared at end of frame");

   a_drain_starts_read: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.command == CMD_DRAIN && fc_ff |=> state_ff == ST_READ)
      else $error("drain transaction did not start a window read");

   a_second_result_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && em2_ff |-> !rsp_data.run_last)
      else $error("run_last set before the second result");

endmodule

@@ design/bblur_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bblur_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 6144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bblur_cell.sv @@
// One window tap: holds a pixel and its in-frame flag, shifts to its neighbor.
module bblur_cell import bblur_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    shift,
   input  tap_type tap_in,
   output tap_type tap_out
);

   logic             vld_ff;
   logic             vld_in;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] pix_in;

   always_comb begin
      vld_in = shift ? tap_in.vld : vld_ff;
      pix_in = shift ? tap_in.pix : pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign tap_out = '{vld: vld_ff, pix: pix_ff};

endmodule

@@ design/bblur_avg.sv @@
// Rounded average of the valid window taps: sum, reciprocal multiply, correct.
module bblur_avg import bblur_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  tap_type    taps [NUM_TAPS],
   output logic       done,
   output logic [7:0] avg [3]
);

   logic                v1_ff, v2_ff, v3_ff;
   logic [SUM_W-1:0]    sum_ff [3];
   logic [SUM_W-1:0]    sum_in [3];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    cnt2_ff;
   logic [NUM_W-1:0]    num_ff [3];
   logic [NUM_W-1:0]    num_in [3];
   logic [PROD_W-1:0]   prod_ff [3];
   logic [PROD_W-1:0]   prod_in [3];
   logic [7:0]          avg_ff [3];
   logic [7:0]          avg_in [3];
   logic [Q_W-1:0]      q0 [3];
   logic [BACK_W-1:0]   back [3];
   logic [BACK_W-1:0]   rem [3];
   logic [DEN_W-1:0]    den;

   always_comb begin
      cnt_in = '0;
      for (int t = 0; t < NUM_TAPS; t++) begin
         cnt_in = cnt_in + CNT_W'(taps[t].vld);
      end
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int t = 0; t < NUM_TAPS; t++) begin
            if (taps[t].vld) begin
               sum_in[ch] = sum_in[ch] + SUM_W'(taps[t].pix[8*ch +: 8]);
            end
         end
      end
   end

   // (2*sum + n) * floor(2^16/2n) lands on the quotient or one below it
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         num_in[ch]  = {sum_ff[ch], 1'b0} + NUM_W'(cnt_ff);
         prod_in[ch] = PROD_W'(num_in[ch]) * PROD_W'(recip(cnt_ff));
      end
   end

   always_comb begin
      den = {cnt2_ff, 1'b0};
      for (int ch = 0; ch < 3; ch++) begin
         q0[ch]   = prod_ff[ch][REC_W +: Q_W];
         back[ch] = BACK_W'(q0[ch]) * BACK_W'(den);
         rem[ch]  = BACK_W'(num_ff[ch]) - back[ch];
         avg_in[ch] = (rem[ch] >= BACK_W'(den)) ? 8'(q0[ch] + Q_W'(1)) : 8'(q0[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      cnt2_ff <= cnt_ff;
      for (int ch = 0; ch < 3; ch++) begin
         sum_ff[ch]  <= sum_in[ch];
         num_ff[ch]  <= num_in[ch];
         prod_ff[ch] <= prod_in[ch];
         avg_ff[ch]  <= avg_in[ch];
      end
   end

   assign done = v3_ff;
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         avg[ch] = avg_ff[ch];
      end
   end

endmodule

@@ tb/tb.sv @@
// Testbench for the 3x3 edge-clipped box blur: directed and random frames against a predictor.
`timescale 1ns / 100ps

module tb;
   import bblur_pkg::*;

   // Expected results are held in order and matched against each accepted result.
   class blur_scoreboard;
      rsp_type pending[$];
      int      errors;
      int      checked;
      int      frames;

      function void note(rsp_type r);
         pending.push_back(r);
      endfunction

      function void check(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.frame_done) frames++;
         if (got.out_red !== exp.out_red) begin
            $error("out_red exp %0d got %0d", exp.out_red, got.out_red);
            errors++;
         end
         if (got.out_green !== exp.out_green) begin
            $error("out_green exp %0d got %0d", exp.out_green, got.out_green);
            errors++;
         end
         if (got.out_blue !== exp.out_blue) begin
            $error("out_blue exp %0d got %0d", exp.out_blue, got.out_blue);
            errors++;
         end
         if (got.frame_done !== exp.frame_done) begin
            $error("frame_done exp %0d got %0d", exp.frame_done, got.frame_done);
            errors++;
         end
         if (got.run_last !== exp.run_last) begin
            $error("run_last exp %0d got %0d", exp.run_last, got.run_last);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_write;
   logic             csr_index;
   logic [CFG_W-1:0] csr_data;

   blur_scoreboard sb;

   // predictor state
   logic [23:0] pix_rows[3][MAX_WIDTH];
   int          cfg_w;
   int          cfg_h;
   int          row_at;
   int          col_at;
   int          drain_at;
   bit          draining;
   int          issued;
   bit          feeding;

   box_blur_3x3_edge_clipped dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int width_eff();
      int w;
      w = cfg_w;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int height_eff();
      return cfg_h == 0 ? 1 : cfg_h;
   endfunction

   function automatic rsp_type blur_at(int row, int x, bit below, int w);
      int      sr, sg, sbl, n;
      rsp_type r;
      logic [23:0] p;
      sr = 0; sg = 0; sbl = 0; n = 0;
      for (int rr = (row >= 1 ? row - 1 : row); rr <= (below ? row + 1 : row); rr++)
         for (int xx = (x >= 1 ? x - 1 : x); xx <= (x + 1 < w ? x + 1 : x); xx++) begin
            p = pix_rows[rr % 3][xx];
            sr += p[23:16];
            sg += p[15:8];
            sbl += p[7:0];
            n++;
         end
      r.out_red    = 8'((2 * sr + n) / (2 * n));
      r.out_green  = 8'((2 * sg + n) / (2 * n));
      r.out_blue   = 8'((2 * sbl + n) / (2 * n));
      r.frame_done = 1'b0;
      r.run_last   = 1'b0;
      return r;
   endfunction

   task automatic predict_blur(req_type t);
      int      w, h, r, c, n;
      rsp_type outs[2];
      w = width_eff();
      h = height_eff();
      n = 0;
      if (t.command == CMD_DRAIN) begin
         if (!draining) return;
         outs[0] = blur_at(h - 1, drain_at, 1'b0, w);
         outs[0].run_last = 1'b1;
         if (drain_at == w - 1) begin
            outs[0].frame_done = 1'b1;
            row_at = 0; col_at = 0; drain_at = 0; draining = 0;
         end else begin
            drain_at++;
         end
         sb.note(outs[0]);
         return;
      end
      if (draining) return;
      r = row_at;
      c = col_at;
      pix_rows[r % 3][c] = {t.in_red, t.in_green, t.in_blue};
      if (r >= 1) begin
         if (c >= 1) outs[n++] = blur_at(r - 1, c - 1, 1'b1, w);
         if (c == w - 1) outs[n++] = blur_at(r - 1, w - 1, 1'b1, w);
         if (n > 0) outs[n - 1].run_last = 1'b1;
      end
      for (int i = 0; i < n; i++) sb.note(outs[i]);
      if (c == w - 1) begin
         col_at = 0;
         if (r == h - 1) begin
            drain_at = 0;
            draining = 1;
         end else begin
            row_at = r + 1;
         end
      end else begin
         col_at = c + 1;
      end
   endtask

   // valid stays high into the next transaction when there is no gap
   task automatic send_item(req_type t);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_blur(t);
      issued++;
   endtask

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_type t;
      t.command  = CMD_PIXEL;
      t.in_red   = r;
      t.in_green = g;
      t.in_blue  = b;
      send_item(t);
   endtask

   task automatic send_drain();
      req_type t;
      t = req_type'(25'($urandom()));
      t.command = CMD_DRAIN;
      send_item(t);
   endtask

   task automatic random_pixel();
      case ($urandom_range(0, 4))
         0: send_pixel(8'hFF, 8'hFF, 8'hFF);
         1: send_pixel(8'h00, 8'h00, 8'h00);
         default: send_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()));
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= CFG_W'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) cfg_w = value & 12'hFFF;
      else cfg_h = value & 12'hFFF;
      @(posedge clock);
   endtask

   // one whole frame, optionally with stray commands mixed in
   task automatic run_frame(bit noise);
      int w, h;
      w = width_eff();
      h = height_eff();
      for (int i = 0; i < w * h; i++) begin
         if (noise && $urandom_range(0, 15) == 0) send_drain();
         random_pixel();
      end
      for (int i = 0; i < w; i++) begin
         if (noise && $urandom_range(0, 7) == 0) random_pixel();
         send_drain();
      end
   endtask

   // result side: random stall per result
   initial begin
      int hold;
      rsp_stall <= 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) sb.check(rsp_data);
         if (rsp_stall) begin
            hold = (feeding && $urandom_range(0, 2) != 0) ? $urandom_range(0, 17) : 0;
            if (hold == 0) rsp_stall <= 1'b0;
            else begin
               repeat (hold - 1) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end else if (rsp_valid) begin
            rsp_stall <= 1'b1;
         end
      end
   end

   initial begin
      sb = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data  <= '0;
      cfg_w = 640; cfg_h = 480;
      row_at = 0; col_at = 0; drain_at = 0; draining = 0; issued = 0;
      feeding = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray drain, small frame with extremes, then tiny shapes
      write_reg(CSR_FRAME_WIDTH, 3);
      write_reg(CSR_FRAME_HEIGHT, 3);
      send_drain();
      send_pixel(8'hFF, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h01, 8'h80, 8'h7F);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hAA, 8'h55, 8'hFE);
      send_pixel(8'h55, 8'hAA, 8'h01);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h12, 8'h34, 8'h56);   // ignored while draining
      send_drain();
      send_drain();
      send_drain();
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 0);     // counts as one column
      write_reg(CSR_FRAME_HEIGHT, 0);    // counts as one row
      run_frame(0);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 4);
      write_reg(CSR_FRAME_HEIGHT, 1);    // drain-only frame
      run_frame(0);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 1);
      write_reg(CSR_FRAME_HEIGHT, 4);
      run_frame(0);
      wait_idle();

      // random frames with various shapes
      while (issued < 1100) begin
         case ($urandom_range(0, 9))
            0: write_reg(CSR_FRAME_WIDTH, $urandom_range(1, 2));
            1: write_reg(CSR_FRAME_WIDTH, $urandom_range(10, 16));   // wider rows
            default: write_reg(CSR_FRAME_WIDTH, $urandom_range(1, 9));
         endcase
         if (cfg_w > 16) write_reg(CSR_FRAME_HEIGHT, 1);
         else write_reg(CSR_FRAME_HEIGHT, $urandom_range(0, 3) == 0 ? $urandom_range(1, 2)
                                                                   : $urandom_range(3, 8));
         run_frame($urandom_range(0, 2) == 0);
         wait_idle();
      end
      // tall frame with minimal width
      write_reg(CSR_FRAME_WIDTH, 1);
      write_reg(CSR_FRAME_HEIGHT, 300);
      run_frame(0);
      feeding = 0;
      wait_idle();

      $display("sent %0d transactions, checked %0d results over %0d frames",
               issued, sb.checked, sb.frames);
      if (sb.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
